FILE: rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of the base field; the multiply unit walks this many multiplier bits.
  localparam int BASE_W = 31;

  // Modulus after reset, before masking to the configured width.
  localparam logic [31:0] MOD_RESET = 32'd1000000007;

  // Fermat inverse uses exponent modulus minus this offset.
  localparam int FERMAT_OFFSET = 2;

  // Register index of the modulus (paddr[2] selects the register).
  localparam logic REG_MODULUS = 1'b0;

  // Operation modes.
  localparam logic MODE_POWER   = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;

  // Status of the shared multiply-reduce unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

FILE: rtl/core/mexp_cfg.sv
// Configuration register file holding the modulus, APB-style access.
`timescale 1ns / 1ps

module mexp_cfg #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [MOD_WIDTH-1:0] modulus
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite && (paddr[2] == mexp_pkg::REG_MODULUS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_WIDTH'(mexp_pkg::MOD_RESET);
    end else if (wr_en) begin
      modulus <= pwdata[MOD_WIDTH-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == mexp_pkg::REG_MODULUS) begin
      prdata = 32'(modulus);
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

FILE: rtl/core/mexp_mulmod.sv
// Bit-serial interleaved multiply-reduce unit: computes (a * b) mod m, a < m.
`timescale 1ns / 1ps

module mexp_mulmod #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MOD_WIDTH-1:0]        a,
  input  logic [mexp_pkg::BASE_W-1:0] b,
  input  logic [MOD_WIDTH-1:0]        m,
  output logic [MOD_WIDTH-1:0]        prod,
  output mexp_pkg::mm_stat_t          stat
);

  localparam int BW = mexp_pkg::BASE_W;
  localparam int CW = $clog2(BW);
  localparam int TW = MOD_WIDTH + 2;

  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] m_r;
  logic [BW-1:0]        b_r;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 done;
  logic [TW-1:0]        t1;
  logic [TW-1:0]        t2;
  logic [TW-1:0]        t3;
  logic [MOD_WIDTH-1:0] acc_next;

  // Double, add the partial product, then fold back below m (at most two subtracts).
  always_comb begin
    t1 = {1'b0, acc, 1'b0} + (b_r[BW-1] ? TW'(a_r) : TW'(0));
    t2 = (t1 >= TW'(m_r)) ? t1 - TW'(m_r) : t1;
    t3 = (t2 >= TW'(m_r)) ? t2 - TW'(m_r) : t2;
    acc_next = t3[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      m_r <= m;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= {b_r[BW-2:0], 1'b0};
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/core/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: sequencer, config and shared unit.
`timescale 1ns / 1ps

// Usage:
//   Operation channel (op_valid / op_stall, fields mode, base, exponent): one
//   transfer starts one computation. mode = power gives base^exponent mod
//   modulus; mode = inverse gives base^(modulus-2) mod modulus and ignores
//   exponent. Result channel (res_valid / res_stall, field result): one
//   transfer per operation, always fully reduced below the modulus; a
//   modulus of 0 or 1 gives 0 without starting the multiply unit.
//   Configuration: APB-style port, modulus at byte address 0. Write it only
//   while the block is idle.
//   One shared bit-serial multiply-reduce unit does all the work, walking all
//   31 multiplier bits for each modular multiply.
//   From the operation transfer, the unit first reduces the base; each
//   exponent bit up to the highest set bit then takes a check, a multiply
//   when the bit is set, and a square; a final check and the output load
//   finish the operation. One operation at a time; op_stall is high until
//   the result is in the output register, and the next operation can
//   transfer from then on.
//   Reset: holds op_stall, clears the sequencer, drops res_valid, loads 1000000007.
//   A stalled result holds in the output register; the next operation is
//   taken meanwhile and waits at its end until the register frees up.
module modular_exponentiation_top #(
  parameter int EXP_WIDTH = 32,
  parameter int MOD_WIDTH = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  // operation channel
  input  logic                        op_valid,
  output logic                        op_stall,
  input  logic                        mode,
  input  logic [mexp_pkg::BASE_W-1:0] base,
  input  logic [EXP_WIDTH-1:0]        exponent,
  // result channel
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [MOD_WIDTH-1:0]        result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Inverse mode uses the full modulus - 2, so the exponent register covers both.
  localparam int EW = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
  localparam int BW = mexp_pkg::BASE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state;
  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] acc;      // running result
  logic [MOD_WIDTH-1:0] sq;       // running square
  logic [EW-1:0]        e;        // remaining exponent bits
  logic                 op_take;
  logic                 out_load;

  // shared unit hookup
  logic                 mm_start;
  logic [MOD_WIDTH-1:0] mm_a;
  logic [BW-1:0]        mm_b;
  logic [MOD_WIDTH-1:0] mm_prod;
  mexp_pkg::mm_stat_t   mm_stat;

  mexp_cfg #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .modulus (modulus)
  );

  mexp_mulmod #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .m     (modulus),
    .prod  (mm_prod),
    .stat  (mm_stat)
  );

  assign op_stall = rst || (state != S_IDLE);
  assign op_take  = op_valid && !op_stall;
  // Move the finished value into the output register once it is free.
  assign out_load = (state == S_OUT) && (!res_valid || !res_stall);

  // Pick the next job for the shared unit.
  always_comb begin
    mm_start = 1'b0;
    mm_a     = sq;
    mm_b     = BW'(sq);
    case (state)
      S_IDLE: begin
        // base mod m computed as 1 * base
        mm_start = op_take && (modulus >= MOD_WIDTH'(2));
        mm_a     = MOD_WIDTH'(1);
        mm_b     = base;
      end
      S_CHK: begin
        if (e != '0) begin
          mm_start = 1'b1;
          if (e[0]) begin
            mm_a = acc;
          end
        end
      end
      S_MUL: begin
        // square right after the multiply
        mm_start = mm_stat.done;
        mm_b     = BW'(sq);
        mm_a     = sq;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (op_take) begin
            if (modulus < MOD_WIDTH'(2)) begin
              state <= S_OUT;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_stat.done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (e == '0) begin
            state <= S_OUT;
          end else if (e[0]) begin
            state <= S_MUL;
          end else begin
            state <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_stat.done) begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_stat.done) begin
            state <= S_CHK;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (op_take) begin
          if (modulus < MOD_WIDTH'(2)) begin
            acc <= '0;
          end else begin
            acc <= MOD_WIDTH'(1);
          end
          if (mode == mexp_pkg::MODE_INVERSE) begin
            e <= EW'(modulus - MOD_WIDTH'(mexp_pkg::FERMAT_OFFSET));
          end else begin
            e <= EW'(exponent);
          end
        end
      end
      S_RED: begin
        if (mm_stat.done) begin
          sq <= mm_prod;
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          acc <= mm_prod;
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          sq <= mm_prod;
          e  <= e >> 1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      result <= acc;
    end
  end

endmodule

FILE: sim/modular_exponentiation_top_test.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module modular_exponentiation_top_test;

  localparam int EXP_W = 32;
  localparam int MOD_W = 31;
  // Cycles with no transfer on either channel before the run is called hung:
  // a worst-case operation behind the long result hold-off,
  // taken several times over.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 4000;
  // Settle time at the end, about one worst-case operation.
  localparam int END_SETTLE = 2200;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic                        mode;
    logic [mexp_pkg::BASE_W-1:0] base;
    logic [EXP_W-1:0]            exponent;
  } power_op_t;

  typedef struct {
    power_op_t        op;
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] result;
  } power_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        op_valid = 1'b0;
  logic                        op_stall;
  logic                        mode = mexp_pkg::MODE_POWER;
  logic [mexp_pkg::BASE_W-1:0] base = '0;
  logic [EXP_W-1:0]            exponent = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  logic [MOD_W-1:0]            result;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  modular_exponentiation_top #(
    .EXP_WIDTH(EXP_W),
    .MOD_WIDTH(MOD_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .mode     (mode),
    .base     (base),
    .exponent (exponent),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .result   (result),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Operations waiting to be offered, and results owed by the block in order.
  power_op_t     pending_ops[$];
  power_expect_t expected_powers[$];

  // Our copy of the modulus register; only changed while the block is idle.
  logic [MOD_W-1:0] modulus_copy = mexp_pkg::MOD_RESET[MOD_W-1:0];

  power_op_t presented_op;
  int ops_accepted = 0;
  int inverse_ops = 0;
  int results_checked = 0;
  int failures = 0;
  int moduli_used = 1;
  int idle_cycles = 0;

  // Append one operation to the sender's list.
  function automatic void add_op(power_op_t op);
    pending_ops = {pending_ops, op};
  endfunction

  // Right-to-left square and multiply, every product fully reduced.
  function automatic logic [MOD_W-1:0] predict_power(power_op_t op, logic [MOD_W-1:0] m);
    logic [63:0] mm;
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] e;
    mm = 64'(m);
    if (mm < 64'd2) return '0;
    e = (op.mode == mexp_pkg::MODE_INVERSE) ? mm - 64'(mexp_pkg::FERMAT_OFFSET)
                                            : 64'(op.exponent);
    acc = 64'd1;
    sq = 64'(op.base) % mm;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      e = e >> 1;
    end
    return acc[MOD_W-1:0];
  endfunction

  function automatic power_op_t mk_op(logic md, logic [mexp_pkg::BASE_W-1:0] b,
                                      logic [EXP_W-1:0] e);
    power_op_t op;
    op.mode = md;
    op.base = b;
    op.exponent = e;
    return op;
  endfunction

  // Random operation: mostly short exponents to keep the run quick, some full width.
  function automatic power_op_t random_op(logic [MOD_W-1:0] m);
    power_op_t op;
    int w;
    int unsigned k;
    op.mode = $urandom_range(1) ? mexp_pkg::MODE_INVERSE : mexp_pkg::MODE_POWER;
    case ($urandom_range(9))
      0: op.base = '0;
      1: op.base = '1;
      2: begin
        // multiple of the modulus, reduces to zero
        if (m != 0) begin
          k = $urandom_range(0, 32'h7FFF_FFFF / {1'b0, m});
          op.base = mexp_pkg::BASE_W'(k * {1'b0, m});
        end else begin
          op.base = '0;
        end
      end
      3, 4: op.base = mexp_pkg::BASE_W'($urandom_range(0, 1000));
      default: op.base = mexp_pkg::BASE_W'($urandom());
    endcase
    w = ($urandom_range(9) < 3) ? $urandom_range(0, EXP_W) : $urandom_range(0, 12);
    op.exponent = (w == 0) ? '0 : EXP_W'($urandom() >> (32 - w));
    return op;
  endfunction

  task automatic queue_random(int n);
    repeat (n) add_op(random_op(modulus_copy));
  endtask

  // Sender stops here until every offered operation has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || op_valid || expected_powers.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_modulus(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {mexp_pkg::REG_MODULUS, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    modulus_copy = value[MOD_W-1:0];
    moduli_used++;
  endtask

  // Driver: offer operations in bursts with random gaps in between.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    power_expect_t fresh;
    if (rst) begin
      op_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (op_valid && !op_stall) begin
        fresh.op = presented_op;
        fresh.modulus = modulus_copy;
        fresh.result = predict_power(presented_op, modulus_copy);
        expected_powers = {expected_powers, fresh};
        ops_accepted++;
        if (presented_op.mode == mexp_pkg::MODE_INVERSE) inverse_ops++;
      end
      // A stalled operation holds; change the payload only once it has moved.
      if (!op_valid || !op_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          op_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          presented_op = pending_ops.pop_front();
          op_valid <= 1'b1;
          mode <= presented_op.mode;
          base <= presented_op.base;
          exponent <= presented_op.exponent;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // New burst; a quarter of them run back to back with no gap after.
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(3) == 0) gap_left = 0;
            else if ($urandom_range(9) == 0) gap_left = $urandom_range(100, 400);
            else gap_left = $urandom_range(1, 30);
          end
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: segments of random length, each with its own stall rate,
  // and one long hold-off so the block fills up and stalls its input.
  int seg_left = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (!hold_done && results_checked >= 20) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      res_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 200);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : monitor
    power_expect_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_powers.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] unexpected result %0d with nothing outstanding", $realtime, result);
      end else begin
        want = expected_powers.pop_front();
        if (result !== want.result) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("[%0t] mismatch: mode=%0d base=%0d exp=%0d mod=%0d expected %0d got %0d",
                     $realtime, want.op.mode, want.op.base, want.op.exponent, want.modulus,
                     want.result, result);
        end
      end
      results_checked++;
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (op_valid && !op_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, expected_powers.size());
        $display("modular_exponentiation_top_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset modulus: zero exponents, extreme bases and exponents, multiples of
    // the modulus, and inverse mode with the exponent field ignored.
    add_op(mk_op(mexp_pkg::MODE_POWER, '0, '0));
    add_op(mk_op(mexp_pkg::MODE_POWER, '1, '0));
    add_op(mk_op(mexp_pkg::MODE_POWER, '0, 32'd5));
    add_op(mk_op(mexp_pkg::MODE_POWER, '1, '1));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd2, 32'd10));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd1000000007, 32'd3));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd1, '1));
    add_op(mk_op(mexp_pkg::MODE_POWER, '1, 32'd1));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd3, 32'h8000_0000));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, 31'd2, '0));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, '0, '1));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, 31'd1000000007, 32'd12345));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, '1, '1));
    queue_random(55);
    wait_drained();

    // Largest modulus; the all-ones base is a multiple of it.
    write_modulus(32'h7FFF_FFFF);
    add_op(mk_op(mexp_pkg::MODE_INVERSE, '1, '0));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'h7FFF_FFFE, 32'd2));
    queue_random(50);
    wait_drained();

    // Small prime; the top data bit is set and must be dropped by the register.
    write_modulus(32'h8000_000D);
    queue_random(45);
    wait_drained();

    // Modulus two: the inverse exponent is zero.
    write_modulus(32'd2);
    add_op(mk_op(mexp_pkg::MODE_INVERSE, 31'd4, '0));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, 31'd3, 32'd5));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd5, '0));
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd6, 32'd7));
    queue_random(20);
    wait_drained();

    // Degenerate moduli zero and one give zero in both modes.
    write_modulus(32'd0);
    add_op(mk_op(mexp_pkg::MODE_POWER, '0, '0));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, '1, '0));
    queue_random(10);
    wait_drained();
    write_modulus(32'd1);
    add_op(mk_op(mexp_pkg::MODE_POWER, 31'd5, '0));
    add_op(mk_op(mexp_pkg::MODE_INVERSE, 31'd3, '0));
    queue_random(10);
    wait_drained();

    // Even modulus, so inverse mode runs on a composite.
    write_modulus(($urandom() & 32'hFFFF_FFFE) | 32'h0000_0100);
    queue_random(37);
    wait_drained();

    // Back to the reset value.
    write_modulus(mexp_pkg::MOD_RESET);
    queue_random(40);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (END_SETTLE) @(posedge clk);

    $display("Covered %0d operations (%0d inverse) over %0d moduli incl. 0, 1, 2, 2^31-1,",
             ops_accepted, inverse_ops, moduli_used);
    $display("with a %0d-cycle result hold-off; %0d results checked, %0d failures.",
             LONG_HOLD, results_checked, failures);
    if (failures == 0 && expected_powers.size() == 0) begin
      $display("modular_exponentiation_top_test: PASS");
    end else begin
      $display("modular_exponentiation_top_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mexp_pkg.sv
rtl/core/mexp_cfg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_top.sv
sim/modular_exponentiation_top_test.sv
